// ===== rtl/knnmc_pkg.sv =====
// Package for the k-nearest-neighbour classifier.
// Holds the shared widths, codes and the structs between the distance unit,
// the neighbour list and the top level. Depends on nothing.
package knnmc_pkg;

	localparam int FEAT_W = 16;
	localparam int DIST_W = 20;
	localparam int CNT_W  = 5;

	localparam logic [DIST_W-1:0] DIST_ONES = '1;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	localparam logic REG_ROWS      = 1'b0;
	localparam logic REG_NEIGHBORS = 1'b1;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} issue_t;

	typedef struct packed {
		logic              done;
		logic [DIST_W-1:0] distance;
		logic              cls;
	} row_res_t;

	typedef struct packed {
		logic              clear;
		logic              insert;
		logic [DIST_W-1:0] distance;
		logic              cls;
		logic [CNT_W-1:0]  kept;
	} nbr_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0]  ones;
		logic [CNT_W-1:0]  zeros;
		logic [DIST_W-1:0] nearest;
	} nbr_sum_t;

endpackage

// ===== rtl/knnmc_dist.sv =====
// Training and query stores with the shared absolute-difference accumulator.
// One feature pair is read per cycle and summed into a row distance.
// Depends on knnmc_pkg.
module knnmc_dist import knnmc_pkg::*; #(
	parameter int MAX_ROWS = 128,
	parameter int FEATURES = 12,
	parameter int AW       = 11,
	parameter int RAW      = 7,
	parameter int FW       = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld_feat_we,
	input  logic              ld_lbl_we,
	input  logic [AW-1:0]     ld_addr,
	input  logic [RAW-1:0]    ld_row,
	input  logic [FEAT_W-1:0] ld_value,
	input  logic              ld_label,
	input  logic              q_we,
	input  logic [FW-1:0]     q_idx,
	input  logic [FEAT_W-1:0] q_value,
	input  issue_t            issue,
	input  logic [AW-1:0]     rd_addr,
	input  logic [RAW-1:0]    rd_row,
	input  logic [FW-1:0]     rd_feat,
	output row_res_t          res,
	output logic              pipe_busy
);

	logic [FEAT_W-1:0] feat_mem [MAX_ROWS*FEATURES];
	logic              lbl_mem [MAX_ROWS];
	logic [FEAT_W-1:0] qry_q [FEATURES];

	logic [FEAT_W-1:0] train_s1;
	logic [FEAT_W-1:0] qry_s1;
	logic              cls_s1;
	issue_t            ctl_s1;
	logic [FEAT_W:0]   diff;
	logic [FEAT_W-1:0] absd_s2;
	logic              cls_s2;
	issue_t            ctl_s2;
	logic [DIST_W-1:0] acc_q;
	logic              cls_q;
	logic              done_q;

	always_ff @(posedge clk) begin
		if (ld_feat_we) begin
			feat_mem[ld_addr] <= ld_value;
		end
		train_s1 <= feat_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ld_lbl_we) begin
			lbl_mem[ld_row] <= ld_label;
		end
		cls_s1 <= lbl_mem[rd_row];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qry_q[q_idx] <= q_value;
		end
		qry_s1 <= qry_q[rd_feat];
	end

	assign diff = {qry_s1[FEAT_W-1], qry_s1} - {train_s1[FEAT_W-1], train_s1};

	always_ff @(posedge clk) begin
		absd_s2 <= diff[FEAT_W] ? FEAT_W'(-diff) : diff[FEAT_W-1:0];
		cls_s2  <= cls_s1;
		cls_q   <= cls_s2;
		if (ctl_s2.valid) begin
			acc_q <= (ctl_s2.first ? '0 : acc_q) + DIST_W'(absd_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= issue;
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	assign res.done     = done_q;
	assign res.distance = acc_q;
	assign res.cls      = cls_q;
	assign pipe_busy    = ctl_s1.valid || ctl_s2.valid || done_q;

endmodule

// ===== rtl/knnmc_nbrs.sv =====
// Sorted list of the nearest rows, one insertion per cycle, and the vote count.
// Every slot compares the new distance in parallel and shifts or loads itself.
// Depends on knnmc_pkg.
module knnmc_nbrs import knnmc_pkg::*; #(
	parameter int NEIGHBORS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  nbr_ctl_t ctl,
	output nbr_sum_t sum
);

	logic [DIST_W-1:0]  dist_q [NEIGHBORS];
	logic [NEIGHBORS-1:0] cls_q;
	logic [NEIGHBORS-1:0] vld_q;
	logic [NEIGHBORS-1:0] hit;
	logic [NEIGHBORS-1:0] first;
	logic [DIST_W-1:0]  prev_dist [NEIGHBORS];
	logic [NEIGHBORS-1:0] prev_cls;
	logic [NEIGHBORS-1:0] prev_vld;

	for (genvar i = 0; i < NEIGHBORS; i++) begin : g_slot
		assign hit[i] = (CNT_W'(i) < ctl.kept) && (!vld_q[i] || ctl.distance < dist_q[i]);
		if (i == 0) begin : g_head
			assign first[i]     = hit[i];
			assign prev_dist[i] = ctl.distance;
			assign prev_cls[i]  = ctl.cls;
			assign prev_vld[i]  = 1'b1;
		end else begin : g_tail
			assign first[i]     = hit[i] && !hit[i-1];
			assign prev_dist[i] = dist_q[i-1];
			assign prev_cls[i]  = cls_q[i-1];
			assign prev_vld[i]  = vld_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cls_q <= '0;
			for (int i = 0; i < NEIGHBORS; i++) begin
				dist_q[i] <= DIST_ONES;
			end
		end else if (ctl.clear) begin
			vld_q <= '0;
			for (int i = 0; i < NEIGHBORS; i++) begin
				dist_q[i] <= DIST_ONES;
			end
		end else if (ctl.insert) begin
			for (int i = 0; i < NEIGHBORS; i++) begin
				if (hit[i]) begin
					dist_q[i] <= first[i] ? ctl.distance : prev_dist[i];
					cls_q[i]  <= first[i] ? ctl.cls : prev_cls[i];
					vld_q[i]  <= first[i] ? 1'b1 : prev_vld[i];
				end
			end
		end
	end

	always_comb begin
		sum.ones  = '0;
		sum.zeros = '0;
		for (int i = 0; i < NEIGHBORS; i++) begin
			sum.ones  = sum.ones + CNT_W'(vld_q[i] && cls_q[i]);
			sum.zeros = sum.zeros + CNT_W'(vld_q[i] && !cls_q[i]);
		end
		sum.nearest = vld_q[0] ? dist_q[0] : DIST_ONES;
	end

endmodule

// ===== rtl/knn_manhattan_binary_classifier.sv =====
// Top level of the k-nearest-neighbour binary classifier with L1 distance.
// Instantiates knnmc_dist and knnmc_nbrs; depends on knnmc_pkg.
//
// Items are given on the command ports and taken at an edge where start is
// high and busy is low. A load beat (command 0) writes one training feature
// and the row label and gives no result. A query beat
// (command 1) writes one query feature; with last_feature set it also starts
// a search and busy rises at once.
// The search streams one feature pair per cycle through the shared
// subtract, absolute and accumulate path, fed by the single read port of the
// training store, and drains that path before the result beat. Each finished
// row is put into the sorted neighbour list while the next row is read.
// The result is shown on class_label, votes_for_one and nearest_distance for
// exactly one cycle with done high; the receiver cannot hold it off, and a
// new item may be taken in that same cycle.
// Reset clears the sequencer, the neighbour list and the configuration
// registers to 75 rows and 8 neighbours; the stores hold no reset value and
// must be loaded before they are searched. The user must write configuration
// over the APB port only while the block is idle; the block does not enforce it.
module knn_manhattan_binary_classifier import knnmc_pkg::*; #(
	parameter int MAX_ROWS  = 128,
	parameter int FEATURES  = 12,
	parameter int NEIGHBORS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic         command,
	input  logic [6:0]   row_index,
	input  logic [3:0]   feature_index,
	input  logic signed [15:0] feature_value,
	input  logic         row_label,
	input  logic         last_feature,
	output logic         done,
	output logic         class_label,
	output logic [3:0]   votes_for_one,
	output logic [19:0]  nearest_distance,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW0 = $clog2(MAX_ROWS * FEATURES);
	localparam int AW  = (AW0 < 1) ? 1 : AW0;
	localparam int RA0 = $clog2(MAX_ROWS);
	localparam int RAW = (RA0 < 1) ? 1 : RA0;
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int RCW = (RW > 8) ? RW : 8;
	localparam int FW0 = $clog2(FEATURES);
	localparam int FW  = (FW0 < 1) ? 1 : FW0;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t            state_q;
	logic [7:0]        rows_in_use_q;
	logic [3:0]        nbrs_in_use_q;
	logic [RW-1:0]     rows_q;
	logic [RW-1:0]     row_q;
	logic [FW-1:0]     feat_q;
	logic [AW-1:0]     addr_q;
	logic [CNT_W-1:0]  kept_q;
	logic              done_q;
	logic              class_q;
	logic [3:0]        votes_q;
	logic [DIST_W-1:0] nearest_q;

	logic              accept;
	logic              go;
	logic              row_ok;
	logic              feat_ok;
	logic [RCW-1:0]    row_ext;
	logic [RCW-1:0]    rows_sat;
	logic [CNT_W-1:0]  kept_sat;
	logic              cfg_we;
	logic              last_feat;
	issue_t            issue;
	row_res_t          res;
	logic              pipe_busy;
	nbr_ctl_t          nbr_ctl;
	nbr_sum_t          nbr_sum;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign go      = accept && (command == CMD_QUERY) && last_feature;
	assign row_ext = RCW'(row_index);
	assign row_ok  = row_ext < RCW'(MAX_ROWS);
	assign feat_ok = {1'b0, feature_index} < 5'(FEATURES);

	assign rows_sat = (RCW'(rows_in_use_q) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS)
	                                                        : RCW'(rows_in_use_q);
	assign kept_sat = ({1'b0, nbrs_in_use_q} > CNT_W'(NEIGHBORS)) ? CNT_W'(NEIGHBORS)
	                                                             : {1'b0, nbrs_in_use_q};

	assign last_feat   = (feat_q == FW'(FEATURES - 1));
	assign issue.valid = (state_q == ST_RUN);
	assign issue.first = (feat_q == '0);
	assign issue.last  = last_feat;

	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_ROWS:      prdata = {24'b0, rows_in_use_q};
			REG_NEIGHBORS: prdata = {28'b0, nbrs_in_use_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= 8'd75;
			nbrs_in_use_q <= 4'd8;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_ROWS:      rows_in_use_q <= pwdata[7:0];
				REG_NEIGHBORS: nbrs_in_use_q <= pwdata[3:0];
				default:       rows_in_use_q <= rows_in_use_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q  <= '0;
			row_q   <= '0;
			feat_q  <= '0;
			addr_q  <= '0;
			kept_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						rows_q  <= RW'(rows_sat);
						kept_q  <= kept_sat;
						row_q   <= '0;
						feat_q  <= '0;
						addr_q  <= '0;
						state_q <= (rows_sat == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					addr_q <= addr_q + 1'b1;
					if (last_feat) begin
						feat_q <= '0;
						row_q  <= row_q + 1'b1;
						if (row_q == rows_q - 1'b1) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						feat_q <= feat_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && !pipe_busy) begin
			class_q   <= !(nbr_sum.zeros > nbr_sum.ones);
			votes_q   <= nbr_sum.ones[3:0];
			nearest_q <= nbr_sum.nearest;
		end
	end

	knnmc_dist #(
		.MAX_ROWS (MAX_ROWS),
		.FEATURES (FEATURES),
		.AW       (AW),
		.RAW      (RAW),
		.FW       (FW)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld_feat_we (accept && (command == CMD_LOAD) && row_ok && feat_ok),
		.ld_lbl_we  (accept && (command == CMD_LOAD) && row_ok),
		.ld_addr    (AW'(row_ext) * AW'(FEATURES) + AW'(feature_index)),
		.ld_row     (row_ext[RAW-1:0]),
		.ld_value   (feature_value),
		.ld_label   (row_label),
		.q_we       (accept && (command == CMD_QUERY) && feat_ok),
		.q_idx      (FW'(feature_index)),
		.q_value    (feature_value),
		.issue      (issue),
		.rd_addr    (addr_q),
		.rd_row     (row_q[RAW-1:0]),
		.rd_feat    (feat_q),
		.res        (res),
		.pipe_busy  (pipe_busy)
	);

	assign nbr_ctl.clear    = go;
	assign nbr_ctl.insert   = res.done;
	assign nbr_ctl.distance = res.distance;
	assign nbr_ctl.cls      = res.cls;
	assign nbr_ctl.kept     = kept_q;

	knnmc_nbrs #(
		.NEIGHBORS (NEIGHBORS)
	) u_nbrs (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (nbr_ctl),
		.sum    (nbr_sum)
	);

	assign done             = done_q;
	assign class_label      = class_q;
	assign votes_for_one    = votes_q;
	assign nearest_distance = nearest_q;

	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DRAIN))
		else $error("Result beat without a finished search.");

	a_insert_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("Row distance finished while the sequencer was idle.");

	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("Last query feature did not start a search.");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && !pipe_busy) |=> done)
		else $error("Drained search gave no result beat.");

endmodule

// ===== tb/knn_verdict_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for knn_manhattan_binary_classifier: mirrors the training store, the query and
// the registers, predicts every classification and compares each result beat with it.
// Depends on knnmc_pkg.
module knn_verdict_checker import knnmc_pkg::*; #(
	parameter int MAX_ROWS  = 128,
	parameter int FEATURES  = 12,
	parameter int NEIGHBORS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               command,
	input  logic [6:0]         row_index,
	input  logic [3:0]         feature_index,
	input  logic signed [15:0] feature_value,
	input  logic               row_label,
	input  logic               last_feature,
	input  logic               done,
	input  logic               class_label,
	input  logic [3:0]         votes_for_one,
	input  logic [19:0]        nearest_distance,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int unsigned        mismatches,
	output int unsigned        outstanding,
	output int unsigned        verdicts_checked
);

	typedef struct packed {
		logic              cls;
		logic [3:0]        ones;
		logic [DIST_W-1:0] nearest;
	} verdict_t;

	logic signed [FEAT_W-1:0] train_feat [MAX_ROWS][FEATURES];
	logic                     train_lbl  [MAX_ROWS];
	logic signed [FEAT_W-1:0] query_feat [FEATURES];
	logic [7:0]               rows_reg;
	logic [3:0]               nbrs_reg;
	verdict_t                 expected_verdicts [$];

	function automatic verdict_t classify_query();
		logic [DIST_W-1:0] list_dist [NEIGHBORS];
		logic              list_cls  [NEIGHBORS];
		logic              list_vld  [NEIGHBORS];
		logic [DIST_W-1:0] row_dist;
		int                rows, kept, ones, zeros, sum, diff, r, f, i, j;
		bit                placed;
		verdict_t          v;
		rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
		kept = (nbrs_reg > NEIGHBORS) ? NEIGHBORS : nbrs_reg;
		for (i = 0; i < NEIGHBORS; i++) begin
			list_dist[i] = DIST_ONES;
			list_cls[i]  = 1'b0;
			list_vld[i]  = 1'b0;
		end
		for (r = 0; r < rows; r++) begin
			sum = 0;
			for (f = 0; f < FEATURES; f++) begin
				diff = int'(query_feat[f]) - int'(train_feat[r][f]);
				sum += (diff < 0) ? -diff : diff;
			end
			row_dist = DIST_W'(sum);
			placed = 1'b0;
			for (i = 0; i < kept; i++) begin
				if (!placed && (!list_vld[i] || row_dist < list_dist[i])) begin
					for (j = kept - 1; j > i; j--) begin
						list_dist[j] = list_dist[j-1];
						list_cls[j]  = list_cls[j-1];
						list_vld[j]  = list_vld[j-1];
					end
					list_dist[i] = row_dist;
					list_cls[i]  = train_lbl[r];
					list_vld[i]  = 1'b1;
					placed = 1'b1;
				end
			end
		end
		ones = 0;
		zeros = 0;
		for (i = 0; i < kept; i++) begin
			if (list_vld[i]) begin
				if (list_cls[i]) begin
					ones++;
				end else begin
					zeros++;
				end
			end
		end
		v.cls = (zeros > ones) ? 1'b0 : 1'b1;
		v.ones = 4'(ones);
		v.nearest = (kept > 0 && list_vld[0]) ? list_dist[0] : DIST_ONES;
		return v;
	endfunction

	always @(posedge clk) begin : monitor
		verdict_t wanted;
		logic [31:0] reg_value;
		if (!arst_n) begin
			rows_reg = 8'd75;
			nbrs_reg = 4'd8;
			expected_verdicts.delete();
			mismatches = 0;
			verdicts_checked = 0;
		end else begin
			// A result beat belongs to an earlier query, so it is checked before
			// a beat accepted at the same edge is predicted.
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: result beat with nothing expected, %s %0d votes %0d nearest %0d",
						$time, "got class", class_label, votes_for_one,
						nearest_distance);
					mismatches++;
				end else begin
					wanted = expected_verdicts.pop_front();
					verdicts_checked++;
					if (class_label !== wanted.cls) begin
						$display("%0t: class_label expected %0d, got %0d",
							$time, wanted.cls, class_label);
						mismatches++;
					end
					if (votes_for_one !== wanted.ones) begin
						$display("%0t: votes_for_one expected %0d, got %0d",
							$time, wanted.ones, votes_for_one);
						mismatches++;
					end
					if (nearest_distance !== wanted.nearest) begin
						$display("%0t: nearest_distance expected %0d, got %0d",
							$time, wanted.nearest, nearest_distance);
						mismatches++;
					end
				end
			end

			if (start && !busy) begin
				if (cmd_t'(command) == CMD_LOAD) begin
					if (row_index < MAX_ROWS) begin
						if (feature_index < FEATURES) begin
							train_feat[row_index][feature_index] = feature_value;
						end
						train_lbl[row_index] = row_label;
					end
				end else begin
					if (feature_index < FEATURES) begin
						query_feat[feature_index] = feature_value;
					end
					if (last_feature) begin
						expected_verdicts.push_back(classify_query());
					end
				end
			end

			if (psel && penable && pready) begin
				reg_value = (paddr[2] == REG_ROWS) ? {24'd0, rows_reg} : {28'd0, nbrs_reg};
				if (pwrite) begin
					if (paddr[2] == REG_ROWS) begin
						rows_reg = pwdata[7:0];
					end else begin
						nbrs_reg = pwdata[3:0];
					end
				end else if (prdata !== reg_value) begin
					$display("%0t: register read at address %0d expected %0d, got %0d",
						$time, paddr, reg_value, prdata);
					mismatches++;
				end
			end
		end
		outstanding = expected_verdicts.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for knn_manhattan_binary_classifier: clock, reset, APB set-up and
// command beats, with knn_verdict_checker alongside doing all prediction and comparison.
// Depends on knnmc_pkg, the classifier RTL and tb/knn_verdict_checker.sv.
module tb;
	import knnmc_pkg::*;

	localparam int MAX_ROWS        = 128;
	localparam int FEATURES        = 12;
	localparam int NEIGHBORS       = 8;
	localparam int PHASES          = 12;
	localparam int PHASE_BEATS     = 110;
	localparam int PHASE_FLOOR     = 30;
	localparam int SETTLE_CYCLES   = 16;
	localparam int RUN_LIMIT_NS    = 30_000_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               command;
	logic [6:0]         row_index;
	logic [3:0]         feature_index;
	logic signed [15:0] feature_value;
	logic               row_label;
	logic               last_feature;
	logic               done;
	logic               class_label;
	logic [3:0]         votes_for_one;
	logic [19:0]        nearest_distance;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int unsigned        mismatches;
	int unsigned        outstanding;
	int unsigned        verdicts_checked;

	bit [FEATURES-1:0]  row_loaded [MAX_ROWS];
	bit [FEATURES-1:0]  query_loaded;
	int                 rows_set = 75;
	int                 nbrs_set = 8;
	int                 idle_pct = 12;
	bit                 small_values;
	int unsigned        beats_sent;
	int unsigned        settings_used;

	knn_manhattan_binary_classifier #(
		.MAX_ROWS (MAX_ROWS),
		.FEATURES (FEATURES),
		.NEIGHBORS(NEIGHBORS)
	) u_top (.*);

	knn_verdict_checker #(
		.MAX_ROWS (MAX_ROWS),
		.FEATURES (FEATURES),
		.NEIGHBORS(NEIGHBORS)
	) u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int active_rows();
		return (rows_set > MAX_ROWS) ? MAX_ROWS : rows_set;
	endfunction

	function automatic logic signed [15:0] pick_value();
		if (small_values) begin
			return 16'(int'($urandom_range(4)) - 2);
		end
		case ($urandom_range(9))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2:       return 16'sh0000;
			3:       return 16'shffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_beat(input cmd_t cmd, input int row, input int feat,
			input logic signed [15:0] value, input logic lbl, input logic lst);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start         <= 1'b1;
		command       <= cmd;
		row_index     <= 7'(row);
		feature_index <= 4'(feat);
		feature_value <= value;
		row_label     <= lbl;
		last_feature  <= lst;
		while (busy) @(negedge clk);
		@(posedge clk);
		beats_sent++;
		if (feat < FEATURES) begin
			if (cmd == CMD_LOAD) begin
				row_loaded[row][feat] = 1'b1;
			end else begin
				query_loaded[feat] = 1'b1;
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_access(input logic wr, input logic idx, input int value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		while (!pready) @(negedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input int rows, input int nbrs);
		settle();
		reg_access(1'b1, REG_ROWS, rows);
		reg_access(1'b1, REG_NEIGHBORS, nbrs);
		reg_access(1'b0, REG_ROWS, 0);
		reg_access(1'b0, REG_NEIGHBORS, 0);
		rows_set = rows;
		nbrs_set = nbrs;
		settings_used++;
	endtask

	// Every row that a search reads, and the whole query, must have been written.
	task automatic prepare_search();
		int r, f;
		for (r = 0; r < active_rows(); r++) begin
			for (f = 0; f < FEATURES; f++) begin
				if (!row_loaded[r][f]) begin
					send_beat(CMD_LOAD, r, f, pick_value(), $urandom_range(1),
						$urandom_range(1));
				end
			end
		end
		for (f = 0; f < FEATURES; f++) begin
			if (!query_loaded[f]) begin
				send_beat(CMD_QUERY, $urandom_range(MAX_ROWS-1), f, pick_value(), 1'b0, 1'b0);
			end
		end
	endtask

	task automatic fill_row(input int row, input logic signed [15:0] value, input logic lbl);
		int f;
		for (f = 0; f < FEATURES; f++) begin
			send_beat(CMD_LOAD, row, f, value, lbl, f[0]);
		end
	endtask

	task automatic ask_all(input logic signed [15:0] value);
		int f;
		for (f = 0; f < FEATURES; f++) begin
			send_beat(CMD_QUERY, 0, f, value, 1'b0, f == FEATURES - 1);
		end
	endtask

	task automatic random_load();
		int row, feat;
		if ($urandom_range(9) < 7 && active_rows() > 0) begin
			row = $urandom_range(active_rows() - 1);
		end else begin
			row = $urandom_range(MAX_ROWS - 1);
		end
		feat = ($urandom_range(9) == 0) ? $urandom_range(15, FEATURES)
		                                : $urandom_range(FEATURES-1);
		send_beat(CMD_LOAD, row, feat, pick_value(), $urandom_range(1), $urandom_range(1));
	endtask

	task automatic query_sequence();
		int k, i, lastf;
		k = $urandom_range(FEATURES);
		for (i = 0; i < k; i++) begin
			send_beat(CMD_QUERY, $urandom_range(MAX_ROWS-1), $urandom_range(FEATURES-1),
				pick_value(), $urandom_range(1), 1'b0);
		end
		prepare_search();
		lastf = ($urandom_range(9) == 0) ? $urandom_range(15, FEATURES)
		                                 : $urandom_range(FEATURES-1);
		send_beat(CMD_QUERY, $urandom_range(MAX_ROWS-1), lastf, pick_value(),
			$urandom_range(1), 1'b1);
		if ($urandom_range(9) == 0) begin
			settle();
		end
	endtask

	initial begin : stimulus
		int phase, pick, rows, nbrs;
		int unsigned target;
		int unsigned plan;
		arst_n        = 1'b0;
		start         = 1'b0;
		command       = 1'b0;
		row_index     = '0;
		feature_index = '0;
		feature_value = '0;
		row_label     = 1'b0;
		last_feature  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		reg_access(1'b0, REG_ROWS, 0);
		reg_access(1'b0, REG_NEIGHBORS, 0);

		// Two equal rows with opposite labels: the earlier row takes the single slot,
		// then with two slots the one-to-one vote goes to label 1.
		configure(2, 1);
		fill_row(0, 16'sh0100, 1'b0);
		fill_row(1, 16'sh0100, 1'b1);
		ask_all(16'sh0080);
		configure(2, 2);
		send_beat(CMD_QUERY, 0, 0, 16'sh0080, 1'b0, 1'b1);
		send_beat(CMD_LOAD, 1, 15, 16'sh1234, 1'b0, 1'b1);
		send_beat(CMD_QUERY, 5, 13, 16'sh4321, 1'b1, 1'b1);

		configure(1, 1);
		fill_row(0, 16'sh7fff, 1'b1);
		ask_all(16'sh8000);
		configure(0, 8);
		send_beat(CMD_QUERY, 0, 0, 16'sh0000, 1'b0, 1'b1);
		configure(2, 0);
		send_beat(CMD_QUERY, 0, 0, 16'sh0000, 1'b0, 1'b1);
		configure(2, 15);
		send_beat(CMD_QUERY, 0, 0, 16'sh0000, 1'b0, 1'b1);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				2:          rows = 0;
				PHASES - 2: rows = MAX_ROWS;
				PHASES - 1: rows = 255;
				default:    rows = ($urandom_range(9) < 7) ? $urandom_range(16, 1) :
					$urandom_range(90, 17);
			endcase
			case (phase)
				1:       nbrs = 15;
				3:       nbrs = 0;
				5:       nbrs = 1;
				7:       nbrs = NEIGHBORS;
				default: nbrs = $urandom_range(15);
			endcase
			configure(rows, nbrs);
			idle_pct = (phase == 4 || phase == 5) ? 0 : 12;
			small_values = (phase % 3 == 1);
			// The beat budget is shared across phases so that bulk row loading in one
			// phase shortens the later ones, while every phase still sees at least PHASE_FLOOR beats.
			plan   = (phase + 1) * PHASE_BEATS;
			target = beats_sent + PHASE_FLOOR;
			if (plan > target) begin
				target = plan;
			end
			while (beats_sent < target) begin
				pick = $urandom_range(99);
				if (pick < 25) begin
					random_load();
				end else if (pick < 35) begin
					send_beat(CMD_QUERY, $urandom_range(MAX_ROWS-1), $urandom_range(15),
						pick_value(), $urandom_range(1), 1'b0);
				end else begin
					query_sequence();
				end
			end
		end

		settle();
		$display("Covered %0d input beats and %0d checked classifications",
			beats_sent, verdicts_checked);
		$display("over %0d register settings, with empty and saturated row and %s",
			settings_used, "neighbour counts, ties and extreme features.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
